[rtl/hosp_pkg.sv]
// ----------------------------------------------------------------------------
// hosp_pkg
// Shared types and constants for the hunk object stream parser.
// ----------------------------------------------------------------------------
package hosp_pkg;

  // Hunk type words.
  localparam logic [31:0] HunkCode   = 32'h0000_03E9;
  localparam logic [31:0] HunkData   = 32'h0000_03EA;
  localparam logic [31:0] HunkBss    = 32'h0000_03EB;
  localparam logic [31:0] HunkReloc  = 32'h0000_03EC;
  localparam logic [31:0] HunkSymbol = 32'h0000_03F0;
  localparam logic [31:0] HunkEnd    = 32'h0000_03F2;
  localparam logic [31:0] HunkHeader = 32'h0000_03F3;

  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  // Default hunk number modulus.
  localparam int unsigned MaxSectionsDefault = 256;

  // Depth of the record queue; must be a power of two of at least two.
  localparam int unsigned QueueDepth = 4;

  // Parser phase.
  typedef enum logic [3:0] {
    PH_TYPE, PH_LIBLEN, PH_LIBSKIP, PH_TABLE, PH_FIRST, PH_LAST, PH_SIZES,
    PH_SKIP, PH_RELCNT, PH_RELTGT, PH_RELOFF, PH_SYMLEN, PH_SYMNAME, PH_SYMVAL,
    PH_SIZEWORD_CODE, PH_SIZEWORD_BSS
  } phase_e;

  // Record kind.
  typedef enum logic [2:0] {
    KIND_RELOC   = 3'd0,
    KIND_SECTION = 3'd1,
    KIND_HEADER  = 3'd2,
    KIND_TABLE   = 3'd3,
    KIND_SUMMARY = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_e;

  // One result record.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  hunk_number;
    logic [7:0]  dest_hunk;
    logic [31:0] value;
    logic [31:0] extra;
    logic [31:0] reloc_count;
    logic        last_of_run;
  } rec_t;

  // Records produced by one word, in order; cnt says how many are valid.
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       r0;
    rec_t       r1;
  } push_t;

endpackage

[rtl/hosp_parser.sv]
// ----------------------------------------------------------------------------
// hosp_parser
// Parser state registers and the single-pass decode of one stream word into
// up to two records.
// ----------------------------------------------------------------------------
module hosp_parser import hosp_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = MaxSectionsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [31:0] word_i,
  input  logic        eos_i,
  output push_t       push_o
);

  localparam logic [16:0] MaxSec = 17'(MAX_SECTIONS);

  phase_e      phase_q, phase_d;
  logic [31:0] words_left_q, words_left_d;
  logic [7:0]  cur_sec_q, cur_sec_d;
  logic [7:0]  rel_tgt_q, rel_tgt_d;
  logic [31:0] byte_pos_q, byte_pos_d;
  logic [7:0]  tbl_idx_q, tbl_idx_d;
  logic [31:0] tbl_len_q, tbl_len_d;
  logic [31:0] first_sec_q, first_sec_d;
  logic [31:0] bss_tot_q, bss_tot_d;
  logic [31:0] hdr_bytes_q, hdr_bytes_d;
  logic [31:0] rel_tot_q, rel_tot_d;
  logic        halted_q, halted_d;

  logic [31:0] wl_dec;
  logic [16:0] sec_inc;
  rec_t        main_rec;
  logic        main_vld;
  rec_t        sum_rec;

  assign wl_dec  = words_left_q - 32'd1;
  assign sec_inc = {9'd0, cur_sec_q} + 17'd1;

  // Decode of one word and the next parser state.
  always_comb begin
    phase_d     = phase_q;
    words_left_d = words_left_q;
    cur_sec_d   = cur_sec_q;
    rel_tgt_d   = rel_tgt_q;
    byte_pos_d  = byte_pos_q;
    tbl_idx_d   = tbl_idx_q;
    tbl_len_d   = tbl_len_q;
    first_sec_d = first_sec_q;
    bss_tot_d   = bss_tot_q;
    hdr_bytes_d = hdr_bytes_q;
    rel_tot_d   = rel_tot_q;
    halted_d    = halted_q;
    main_vld    = 1'b0;
    main_rec    = '0;

    if (!halted_q) begin
      byte_pos_d = byte_pos_q + 32'd4;
      case (phase_q)
        PH_TYPE: begin
          if (word_i == HunkHeader) begin
            tbl_idx_d = '0;
            phase_d   = PH_LIBLEN;
          end else if (word_i == HunkCode || word_i == HunkData) begin
            phase_d = PH_SIZEWORD_CODE;
          end else if (word_i == HunkBss) begin
            phase_d = PH_SIZEWORD_BSS;
          end else if (word_i == HunkReloc) begin
            phase_d = PH_RELCNT;
          end else if (word_i == HunkSymbol) begin
            phase_d = PH_SYMLEN;
          end else if (word_i == HunkEnd) begin
            cur_sec_d = (sec_inc == MaxSec) ? 8'd0 : sec_inc[7:0];
          end else begin
            main_vld       = 1'b1;
            main_rec.kind  = KIND_ERROR;
            main_rec.extra = word_i;
            halted_d       = 1'b1;
          end
        end
        PH_LIBLEN: begin
          if (word_i == '0) begin
            phase_d = PH_TABLE;
          end else begin
            words_left_d = word_i;
            phase_d      = PH_LIBSKIP;
          end
        end
        PH_LIBSKIP: begin
          words_left_d = wl_dec;
          if (wl_dec == '0) phase_d = PH_LIBLEN;
        end
        PH_TABLE: begin
          tbl_len_d = word_i;
          phase_d   = PH_FIRST;
        end
        PH_FIRST: begin
          first_sec_d = word_i;
          phase_d     = PH_LAST;
        end
        PH_LAST: begin
          main_vld       = 1'b1;
          main_rec.kind  = KIND_HEADER;
          main_rec.value = first_sec_q;
          main_rec.extra = word_i;
          words_left_d   = tbl_len_q;
          if (tbl_len_q == '0) begin
            hdr_bytes_d = byte_pos_d;
            phase_d     = PH_TYPE;
          end else begin
            phase_d = PH_SIZES;
          end
        end
        PH_SIZES: begin
          main_vld             = 1'b1;
          main_rec.kind        = KIND_TABLE;
          main_rec.hunk_number = tbl_idx_q;
          main_rec.value       = word_i;
          tbl_idx_d            = tbl_idx_q + 8'd1;
          words_left_d         = wl_dec;
          if (wl_dec == '0) begin
            hdr_bytes_d = byte_pos_d;
            phase_d     = PH_TYPE;
          end
        end
        PH_SIZEWORD_CODE: begin
          main_vld             = 1'b1;
          main_rec.kind        = KIND_SECTION;
          main_rec.hunk_number = cur_sec_q;
          main_rec.value       = byte_pos_d;
          words_left_d         = word_i;
          phase_d              = (word_i == '0) ? PH_TYPE : PH_SKIP;
        end
        PH_SIZEWORD_BSS: begin
          main_vld             = 1'b1;
          main_rec.kind        = KIND_SECTION;
          main_rec.hunk_number = cur_sec_q;
          main_rec.value       = byte_pos_d;
          bss_tot_d            = bss_tot_q + {word_i[29:0], 2'b00};
          phase_d              = PH_TYPE;
        end
        PH_SKIP: begin
          words_left_d = wl_dec;
          if (wl_dec == '0) phase_d = PH_TYPE;
        end
        PH_RELCNT: begin
          // An all-ones count is ignored and the next word is read as a count.
          if (word_i == '0) begin
            phase_d = PH_TYPE;
          end else if (word_i != AllOnes) begin
            words_left_d = word_i;
            phase_d      = PH_RELTGT;
          end
        end
        PH_RELTGT: begin
          rel_tgt_d = word_i[7:0];
          phase_d   = PH_RELOFF;
        end
        PH_RELOFF: begin
          main_vld             = 1'b1;
          main_rec.kind        = KIND_RELOC;
          main_rec.hunk_number = cur_sec_q;
          main_rec.dest_hunk   = rel_tgt_q;
          main_rec.value       = word_i;
          if (rel_tot_q != AllOnes) rel_tot_d = rel_tot_q + 32'd1;
          words_left_d = wl_dec;
          if (wl_dec == '0) phase_d = PH_RELCNT;
        end
        PH_SYMLEN: begin
          if (word_i == '0) begin
            phase_d = PH_TYPE;
          end else begin
            words_left_d = word_i;
            phase_d      = PH_SYMNAME;
          end
        end
        PH_SYMNAME: begin
          words_left_d = wl_dec;
          if (wl_dec == '0) phase_d = PH_SYMVAL;
        end
        PH_SYMVAL: begin
          phase_d = PH_SYMLEN;
        end
        default: begin
          phase_d = PH_TYPE;
        end
      endcase
    end

    // Summary from the state left by this word.
    sum_rec             = '0;
    sum_rec.kind        = KIND_SUMMARY;
    sum_rec.hunk_number = cur_sec_d;
    sum_rec.value       = bss_tot_d;
    sum_rec.extra       = hdr_bytes_d;
    sum_rec.reloc_count = rel_tot_d;
    sum_rec.last_of_run = 1'b1;

    // Pack records in order and flag the final one.
    push_o = '0;
    if (main_vld) begin
      push_o.r0             = main_rec;
      push_o.r0.last_of_run = !eos_i;
      push_o.r1             = sum_rec;
      push_o.cnt            = eos_i ? 2'd2 : 2'd1;
    end else begin
      push_o.r0  = sum_rec;
      push_o.cnt = eos_i ? 2'd1 : 2'd0;
    end
    if (!take_i) push_o.cnt = 2'd0;

    // The end of the stream returns everything to the reset state.
    if (eos_i) begin
      phase_d      = PH_TYPE;
      words_left_d = '0;
      cur_sec_d    = '0;
      rel_tgt_d    = '0;
      byte_pos_d   = '0;
      tbl_idx_d    = '0;
      tbl_len_d    = '0;
      first_sec_d  = '0;
      bss_tot_d    = '0;
      hdr_bytes_d  = '0;
      rel_tot_d    = '0;
      halted_d     = 1'b0;
    end
  end

  // Parser state registers, updated on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TYPE;
      words_left_q <= '0;
      cur_sec_q    <= '0;
      rel_tgt_q    <= '0;
      byte_pos_q   <= '0;
      tbl_idx_q    <= '0;
      tbl_len_q    <= '0;
      first_sec_q  <= '0;
      bss_tot_q    <= '0;
      hdr_bytes_q  <= '0;
      rel_tot_q    <= '0;
      halted_q     <= 1'b0;
    end else if (take_i) begin
      phase_q      <= phase_d;
      words_left_q <= words_left_d;
      cur_sec_q    <= cur_sec_d;
      rel_tgt_q    <= rel_tgt_d;
      byte_pos_q   <= byte_pos_d;
      tbl_idx_q    <= tbl_idx_d;
      tbl_len_q    <= tbl_len_d;
      first_sec_q  <= first_sec_d;
      bss_tot_q    <= bss_tot_d;
      hdr_bytes_q  <= hdr_bytes_d;
      rel_tot_q    <= rel_tot_d;
      halted_q     <= halted_d;
    end
  end

endmodule

[rtl/hosp_rec_fifo.sv]
// ----------------------------------------------------------------------------
// hosp_rec_fifo
// Small record queue that takes up to two records per cycle and hands out
// one per cycle on the output channel while out_stall_i is low.
// ----------------------------------------------------------------------------
module hosp_rec_fifo import hosp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room2_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output rec_t  rec_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = PtrW + 1;
  localparam logic [CntW-1:0] DepthC = CntW'(QueueDepth);

  rec_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_p1;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign rec_o       = mem_q[rd_ptr_q];
  assign room2_o     = (DepthC - cnt_q) >= CntW'(2);
  assign wr_ptr_p1   = wr_ptr_q + PtrW'(1);

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr_p1] <= push_i.r1;
  end

endmodule

[rtl/hunk_object_stream_parser.sv]
// ----------------------------------------------------------------------------
// hunk_object_stream_parser
// Parses a stream of hunk-format executable words into result records.
// ----------------------------------------------------------------------------
// The parser takes one 32-bit word per clock cycle and decodes it in the
// same cycle into at most two records (one hunk record and, on the word
// flagged as end of stream, a summary), which enter a four-entry record
// queue. Each record is written into the queue before it appears on the
// output, and one record leaves per cycle while out_stall_i is low. Input
// is stalled whenever the queue has fewer than two free entries, so a
// sustained rate of one word per cycle holds as long as words produce on
// average no more than one record each and the output side keeps up; the
// queue drain rate of one record per cycle sets the limit otherwise.
module hunk_object_stream_parser import hosp_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = MaxSectionsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  hunk_number_o,
  output logic [7:0]  dest_hunk_o,
  output logic [31:0] value_o,
  output logic [31:0] extra_o,
  output logic [31:0] reloc_count_o,
  output logic        last_of_run_o
);

  logic  room2;
  logic  take;
  push_t push;
  rec_t  rec;

  // Input handshake.
  assign in_stall_o = !room2;
  assign take       = in_valid_i && room2;

  hosp_parser #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .word_i (word_i),
    .eos_i  (end_of_stream_i),
    .push_o (push)
  );

  hosp_rec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rec_o       (rec)
  );

  // Output fields.
  assign kind_o        = rec.kind;
  assign hunk_number_o = rec.hunk_number;
  assign dest_hunk_o   = rec.dest_hunk;
  assign value_o       = rec.value;
  assign extra_o       = rec.extra;
  assign reloc_count_o = rec.reloc_count;
  assign last_of_run_o = rec.last_of_run;

endmodule
